>>> src/open_address_hash_table_macros.svh
// Assertion helpers shared by the hash table modules.
`ifndef OPEN_ADDRESS_HASH_TABLE_MACROS_SVH
`define OPEN_ADDRESS_HASH_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OAHT_ASSERT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define OAHT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/oaht_pkg.sv
package oaht_pkg;

    // Field widths of the stream words.
    localparam int FUNC_W     = 1;
    localparam int KEY_W      = 31;
    localparam int PAY_W      = 32;
    localparam int STATUS_W   = 2;
    localparam int SLOT_OUT_W = 12;
    localparam int LIMIT_W    = 12;
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 48;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd4093;

    // Defaults for the top level parameters.
    localparam int TABLE_SIZE_DEF = 4093;
    localparam int DIVIDER_DEF    = 2039;
    localparam int DATA_WIDTH_DEF = 32;

    // Remainder unit: eight bits per cycle over a 32-bit operand.
    localparam int MOD_VAL_W  = 32;
    localparam int MOD_DIGIT  = 8;
    localparam int MOD_CHUNKS = MOD_VAL_W / MOD_DIGIT;
    localparam int MOD_CNT_W  = $clog2(MOD_CHUNKS);

    typedef enum logic [0:0] {
        FUNC_INSERT = 1'b0,
        FUNC_SEARCH = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        RS_INSERTED = 2'd0,
        RS_FOUND    = 2'd1,
        RS_ABSENT   = 2'd2,
        RS_FULL     = 2'd3
    } rstat_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_FOLD,
        S_PROBE_RD,
        S_PROBE_CHK,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic clear;
        logic accept;
        logic fold_start;
        logic probe_init;
        logic advance;
        logic finish;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic mod_done;
        logic stop;
        logic last;
    } dp_stat_t;

endpackage

>>> src/oaht_mod_unit.sv
`include "open_address_hash_table_macros.svh"

module oaht_mod_unit import oaht_pkg::*; #(
    parameter int MOD_W = 17
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [MOD_VAL_W-1:0] value,
    input  logic [MOD_W-1:0]     modulus,
    output logic                 done,
    output logic [MOD_W-1:0]     rem
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [MOD_CNT_W-1:0] cnt_reg;
    logic [MOD_VAL_W-1:0] val_reg;
    logic [MOD_W-1:0]     mod_reg;
    logic [MOD_W-1:0]     rem_reg;
    logic [MOD_W-1:0]     rem_next;

    // Restoring remainder, one digit of the operand per cycle, MSB first.
    always_comb begin
        logic [MOD_W-1:0] r;
        r = rem_reg;
        for (int b = 0; b < MOD_DIGIT; b++) begin
            r = {r[MOD_W-2:0], val_reg[MOD_VAL_W-1-b]};
            if (r >= mod_reg) begin
                r = r - mod_reg;
            end
        end
        rem_next = r;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + MOD_CNT_W'(1);
            if (cnt_reg == MOD_CNT_W'(MOD_CHUNKS - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            val_reg <= value;
            mod_reg <= modulus;
            rem_reg <= '0;
        end else if (busy_reg) begin
            val_reg <= {val_reg[MOD_VAL_W-MOD_DIGIT-1:0], {MOD_DIGIT{1'b0}}};
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

    `OAHT_ASSERT(a_rem_reduced, aclk, aresetn, done_reg, rem_reg < mod_reg, "remainder not reduced")

endmodule

>>> src/oaht_datapath.sv
`include "open_address_hash_table_macros.svh"

module oaht_datapath import oaht_pkg::*; #(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF,
    parameter int DIVIDER    = DIVIDER_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [FUNC_W-1:0]    s_tuser,
    input  logic                 cfg_wr_en,
    input  logic [LIMIT_W-1:0]   cfg_wr_data,
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int SLOT_W = $clog2(TABLE_SIZE);
    localparam int HOME_W = $clog2(DIVIDER);
    localparam int MOD_W  = ((HOME_W > SLOT_W) ? HOME_W : SLOT_W) + 1;
    localparam int MEM_W  = 1 + KEY_W + DATA_WIDTH;
    localparam logic [SLOT_W:0]   TS_EXT  = TABLE_SIZE[SLOT_W:0];
    localparam logic [SLOT_W-1:0] TS_LAST = SLOT_W'(TABLE_SIZE - 1);

    function automatic logic [SLOT_W-1:0] mod_add(input logic [SLOT_W-1:0] a,
                                                  input logic [SLOT_W-1:0] b);
        logic [SLOT_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= TS_EXT) begin
            sum = sum - TS_EXT;
        end
        return sum[SLOT_W-1:0];
    endfunction

    logic [KEY_W-1:0] in_key;
    logic [PAY_W-1:0] in_pay;
    func_t            in_func;

    assign in_key  = s_tdata[KEY_W-1:0];
    assign in_pay  = s_tdata[KEY_W +: PAY_W];
    assign in_func = func_t'(s_tuser[0]);

    logic [LIMIT_W-1:0]    limit_reg;
    func_t                 op_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [DATA_WIDTH-1:0] pay_reg;
    logic [LIMIT_W-1:0]    lim_last_reg;
    logic [SLOT_W-1:0]     s_reg;
    logic [SLOT_W-1:0]     step_reg;
    logic [SLOT_W-1:0]     h1_reg;
    logic [LIMIT_W-1:0]    n_reg;
    logic [SLOT_W-1:0]     clr_reg;
    logic [MEM_W-1:0]      rd_q;
    rstat_t                res_status_reg;
    logic [SLOT_W-1:0]     res_slot_reg;
    logic [DATA_WIDTH-1:0] res_pay_reg;
    logic [M_TDATA_W-1:0]  out_reg;

    logic [MEM_W-1:0] mem [TABLE_SIZE];

    // Remainder unit shared by key mod DIVIDER and home mod TABLE_SIZE.
    logic                 mod_start;
    logic [MOD_VAL_W-1:0] mod_value;
    logic [MOD_W-1:0]     mod_modulus;
    logic                 mod_done;
    logic [MOD_W-1:0]     mod_rem;

    assign mod_start   = cmd.accept | cmd.fold_start;
    assign mod_value   = cmd.fold_start ? MOD_VAL_W'(mod_rem) : MOD_VAL_W'(in_key);
    assign mod_modulus = cmd.fold_start ? MOD_W'(TABLE_SIZE) : MOD_W'(DIVIDER);

    oaht_mod_unit #(
        .MOD_W (MOD_W)
    ) u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mod_start),
        .value   (mod_value),
        .modulus (mod_modulus),
        .done    (mod_done),
        .rem     (mod_rem)
    );

    // Effective probe limit: zero counts as one, clamp to the table size.
    logic [LIMIT_W-1:0] lim_one;
    logic [LIMIT_W-1:0] lim_eff;

    always_comb begin
        lim_one = (limit_reg == '0) ? LIMIT_W'(1) : limit_reg;
        if (32'(lim_one) > TABLE_SIZE) begin
            lim_eff = LIMIT_W'(TABLE_SIZE);
        end else begin
            lim_eff = lim_one;
        end
    end

    // First slot and first step, both taken from home mod TABLE_SIZE.
    logic [SLOT_W-1:0] s0;
    logic [SLOT_W-1:0] h1;

    assign s0 = mod_rem[SLOT_W-1:0];
    assign h1 = (s0 == TS_LAST) ? '0 : s0 + SLOT_W'(1);

    logic                  rd_valid;
    logic [KEY_W-1:0]      rd_key;
    logic [DATA_WIDTH-1:0] rd_data;
    logic                  key_hit;

    assign rd_valid = rd_q[MEM_W-1];
    assign rd_key   = rd_q[DATA_WIDTH +: KEY_W];
    assign rd_data  = rd_q[DATA_WIDTH-1:0];
    assign key_hit  = rd_valid && (rd_key == key_reg);

    always_comb begin
        stat.clear_last = (clr_reg == TS_LAST);
        stat.mod_done   = mod_done;
        stat.stop       = (op_reg == FUNC_INSERT) ? !rd_valid : (!rd_valid || key_hit);
        stat.last       = (n_reg == lim_last_reg);
    end

    // Result of the closing probe.
    rstat_t                res_status;
    logic [SLOT_W-1:0]     res_slot;
    logic [DATA_WIDTH-1:0] res_pay;
    logic                  ins_wr;

    always_comb begin
        res_status = RS_ABSENT;
        res_slot   = '0;
        res_pay    = '0;
        ins_wr     = 1'b0;
        unique case (op_reg)
            FUNC_INSERT: begin
                if (!rd_valid) begin
                    res_status = RS_INSERTED;
                    res_slot   = s_reg;
                    ins_wr     = cmd.finish;
                end else begin
                    res_status = RS_FULL;
                end
            end
            FUNC_SEARCH: begin
                if (key_hit) begin
                    res_status = RS_FOUND;
                    res_slot   = s_reg;
                    res_pay    = rd_data;
                end
            end
            default: res_status = RS_ABSENT;
        endcase
    end

    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    logic [MEM_W-1:0]  mem_wdata;

    assign mem_we    = cmd.clear | ins_wr;
    assign mem_waddr = cmd.clear ? clr_reg : s_reg;
    assign mem_wdata = cmd.clear ? '0 : {1'b1, key_reg, pay_reg};

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_q <= mem[s_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
            clr_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            if (cmd.clear) begin
                clr_reg <= clr_reg + SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg       <= in_func;
            key_reg      <= in_key;
            pay_reg      <= DATA_WIDTH'(in_pay);
            lim_last_reg <= lim_eff - LIMIT_W'(1);
        end
        if (cmd.probe_init) begin
            s_reg    <= s0;
            step_reg <= h1;
            h1_reg   <= h1;
            n_reg    <= '0;
        end else if (cmd.advance) begin
            s_reg    <= mod_add(s_reg, step_reg);
            step_reg <= mod_add(step_reg, h1_reg);
            n_reg    <= n_reg + LIMIT_W'(1);
        end
        if (cmd.finish) begin
            res_status_reg <= res_status;
            res_slot_reg   <= res_slot;
            res_pay_reg    <= res_pay;
        end
        if (cmd.out_load) begin
            out_reg <= M_TDATA_W'({PAY_W'(res_pay_reg), SLOT_OUT_W'(res_slot_reg),
                                   res_status_reg});
        end
    end

    assign m_tdata = out_reg;

    `OAHT_ASSERT_NEXT(a_slot_in_range, aclk, aresetn, cmd.advance, (s_reg < TABLE_SIZE) && (step_reg < TABLE_SIZE), "probe slot or step out of range")
    `OAHT_ASSERT(a_no_advance_at_limit, aclk, aresetn, cmd.advance, n_reg != lim_last_reg, "probe past limit")

endmodule

>>> src/oaht_ctrl.sv
`include "open_address_hash_table_macros.svh"

module oaht_ctrl import oaht_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clear = 1'b1;
                if (stat.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = S_HASH;
                end
            end
            S_HASH: begin
                if (stat.mod_done) begin
                    cmd.fold_start = 1'b1;
                    state_next     = S_FOLD;
                end
            end
            S_FOLD: begin
                if (stat.mod_done) begin
                    cmd.probe_init = 1'b1;
                    state_next     = S_PROBE_RD;
                end
            end
            S_PROBE_RD: begin
                state_next = S_PROBE_CHK;
            end
            S_PROBE_CHK: begin
                if (stat.stop || stat.last) begin
                    cmd.finish = 1'b1;
                    state_next = S_EMIT;
                end else begin
                    cmd.advance = 1'b1;
                    state_next  = S_PROBE_RD;
                end
            end
            S_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase

        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_tvalid = m_valid_reg;

    `OAHT_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready, "accepted a word while busy")
    `OAHT_ASSERT(a_mod_done_state, aclk, aresetn, stat.mod_done, (state_reg == S_HASH) || (state_reg == S_FOLD), "remainder finished outside hashing")

endmodule

>>> src/open_address_hash_table.sv
// Open-addressing hash table engine. Each input word is an insert (s_tuser = 0) or a
// search (s_tuser = 1) on a 31-bit key; every word yields exactly one result word with
// a status (inserted, found, not found, table full), the slot used and, on a hit, the
// stored payload. The home value is key mod DIVIDER, the first slot is home mod
// TABLE_SIZE, and probe i moves the slot by i*(home+1) mod TABLE_SIZE. Inserts take
// the first free slot without a duplicate check; searches stop on a match or a free
// slot. cfg_wr_en/cfg_wr_data set the probe limit (zero acts as one, values above
// TABLE_SIZE are clamped); write it only while the engine is idle. After reset the
// engine sweeps the table to clear the valid bits and holds s_tready low until the
// sweep ends. One word is processed at a time: hashing makes two passes through an
// 8-bit-per-cycle remainder unit, and each probe passes through a read state and a
// check state on the table memory, which has a registered read port and a separate
// write port. A finished result sits in the output register, and the next word is
// accepted while it waits.
module open_address_hash_table import oaht_pkg::*; #(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF,
    parameter int DIVIDER    = DIVIDER_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    // Request channel.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [30:0] item_key, [62:31] payload, [63] zero
    input  logic [FUNC_W-1:0]    s_tuser,   // [0] func

    // Result channel.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [1:0] status, [13:2] slot_index,
                                            // [45:14] found_payload, [47:46] zero

    // Probe limit register.
    input  logic                 cfg_wr_en,
    input  logic [LIMIT_W-1:0]   cfg_wr_data
);

    // Commands from the sequencer, status back from the datapath.
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencer: clear sweep, hashing, probe loop, result handoff.
    oaht_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // Datapath: remainder unit, slot/step arithmetic, table memory, output register.
    oaht_datapath #(
        .TABLE_SIZE (TABLE_SIZE),
        .DIVIDER    (DIVIDER),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tdata     (m_tdata)
    );

endmodule

>>> tb/open_address_hash_table_test.sv
`timescale 1ns / 1ps

module open_address_hash_table_test;
    import oaht_pkg::*;

    localparam int SLOTS       = TABLE_SIZE_DEF;
    localparam int DIV         = DIVIDER_DEF;
    // Long enough for a full-length scan over all SLOTS slots and for the clearing
    // sweep after reset, with a wide margin.
    localparam int STALL_LIMIT = 60000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 105;
    localparam int HOT_HOMES   = 5;

    typedef struct {
        rstat_t                status;
        logic [SLOT_OUT_W-1:0] slot;
        logic [PAY_W-1:0]      payload;
    } reply_t;

    // Shadow copy of the table; predicts one reply per accepted request.
    class slot_tracker;
        bit                 slot_used [SLOTS];
        logic [KEY_W-1:0]   slot_key  [SLOTS];
        logic [PAY_W-1:0]   slot_word [SLOTS];
        logic [LIMIT_W-1:0] limit_reg;
        reply_t             replies_due[$];
        int                 mismatches;

        function new();
            limit_reg  = LIMIT_RESET;
            mismatches = 0;
        endfunction

        function void write_limit(logic [LIMIT_W-1:0] v);
            limit_reg = v;
        endfunction

        function void note_request(func_t op, logic [KEY_W-1:0] key, logic [PAY_W-1:0] pay);
            reply_t      r;
            int unsigned home;
            int unsigned slot;
            int unsigned span;
            int unsigned n;
            bit          done;
            home = int'(key) % DIV;
            slot = home % SLOTS;
            span = (limit_reg == 0) ? 1 : int'(limit_reg);
            if (span > SLOTS) span = SLOTS;
            r.status  = (op == FUNC_INSERT) ? RS_FULL : RS_ABSENT;
            r.slot    = '0;
            r.payload = '0;
            done      = 1'b0;
            n         = 0;
            while (!done && n < span) begin
                if (op == FUNC_INSERT) begin
                    // first free slot wins, duplicates allowed
                    if (!slot_used[slot]) begin
                        slot_used[slot] = 1'b1;
                        slot_key[slot]  = key;
                        slot_word[slot] = pay;
                        r.status        = RS_INSERTED;
                        r.slot          = SLOT_OUT_W'(slot);
                        done            = 1'b1;
                    end
                end else if (!slot_used[slot]) begin
                    done = 1'b1;
                end else if (slot_key[slot] == key) begin
                    r.status  = RS_FOUND;
                    r.slot    = SLOT_OUT_W'(slot);
                    r.payload = slot_word[slot];
                    done      = 1'b1;
                end
                if (!done) begin
                    n++;
                    slot = (slot + (n * (home + 1)) % SLOTS) % SLOTS;
                end
            end
            replies_due.push_back(r);
        endfunction

        function void check_reply(logic [M_TDATA_W-1:0] word);
            reply_t                want;
            rstat_t                got_status;
            logic [SLOT_OUT_W-1:0] got_slot;
            logic [PAY_W-1:0]      got_pay;
            got_status = rstat_t'(word[1:0]);
            got_slot   = word[13:2];
            got_pay    = word[45:14];
            if (replies_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d slot %0d payload %h",
                             got_status, got_slot, got_pay);
            end else begin
                want = replies_due.pop_front();
                if (want.status != got_status || want.slot != got_slot ||
                    want.payload != got_pay) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected status %0d slot %0d payload %h, %s",
                                 want.status, want.slot, want.payload,
                                 $sformatf("got status %0d slot %0d payload %h",
                                           got_status, got_slot, got_pay));
                end
            end
        endfunction

        function int outstanding();
            return replies_due.size();
        endfunction
    endclass

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 s_tvalid    = 1'b0;
    wire                  s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;  // [30:0] item_key, [62:31] payload, [63] zero
    logic [FUNC_W-1:0]    s_tuser     = '0;  // [0] func
    wire                  m_tvalid;
    logic                 m_tready    = 1'b0;
    wire  [M_TDATA_W-1:0] m_tdata;           // [1:0] status, [13:2] slot_index,
                                             // [45:14] found_payload, [47:46] zero
    logic                 cfg_wr_en   = 1'b0;
    logic [LIMIT_W-1:0]   cfg_wr_data = '0;

    bit                   steady      = 1'b0;  // suppress idling on both sides
    int unsigned          quiet_cycles = 0;
    int unsigned          hot_home[HOT_HOMES];
    slot_tracker          book;

    always #5 aclk = ~aclk;

    open_address_hash_table #(
        .TABLE_SIZE (SLOTS),
        .DIVIDER    (DIV),
        .DATA_WIDTH (PAY_W)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Stall the result side at random about 6 percent of the time, except in the steady stretch.
    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= 6);
    end

    // Check every accepted result word; end the run if traffic stops for too long.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) book.check_reply(m_tdata);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("[open_address_hash_table] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Present one request word, optionally after a short gap, and hold it until taken.
    task automatic send_request(func_t op, logic [KEY_W-1:0] key, logic [PAY_W-1:0] pay);
        int unsigned gap;
        gap = 0;
        if (!steady && $urandom_range(99) < 6) gap = $urandom_range(4, 1);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, pay, key};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        book.note_request(op, key, pay);
    endtask

    // Drain all pending results, let the engine settle, then write the probe limit.
    task automatic set_probe_limit(logic [LIMIT_W-1:0] v);
        s_tvalid <= 1'b0;
        while (book.outstanding() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        book.write_limit(v);
    endtask

    // Key whose home is h, so that it shares the probe chain of every other such key.
    function automatic logic [KEY_W-1:0] key_at_home(int unsigned h);
        int unsigned reach;
        reach = (32'h7FFF_FFFF - h) / DIV;
        return KEY_W'(h + DIV * $urandom_range(reach, 0));
    endfunction

    initial begin
        logic [KEY_W-1:0]   known[$];
        logic [LIMIT_W-1:0] plan[PHASES];
        func_t              op;
        logic [KEY_W-1:0]   key;
        int unsigned        pick;
        book = new();
        hot_home[0] = 0;
        hot_home[1] = DIV - 1;
        for (int h = 2; h < HOT_HOMES; h++) hot_home[h] = $urandom_range(DIV - 2, 1);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty table, key and payload extremes, collisions on home zero.
        send_request(FUNC_SEARCH, '0, '0);
        send_request(FUNC_INSERT, '0, '0);
        send_request(FUNC_INSERT, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_request(FUNC_SEARCH, 31'h7FFF_FFFF, 32'h1234_5678);
        send_request(FUNC_INSERT, KEY_W'(DIV), 32'hA5A5_A5A5);
        send_request(FUNC_INSERT, '0, 32'h5A5A_5A5A);        // duplicate key
        send_request(FUNC_SEARCH, '0, '0);
        send_request(FUNC_SEARCH, KEY_W'(2 * DIV), '0);       // miss after a chain
        send_request(FUNC_SEARCH, KEY_W'(DIV), 32'hFFFF_FFFF);

        // Limit of one: insert reports full, search gives up.
        set_probe_limit(12'd1);
        send_request(FUNC_INSERT, KEY_W'(2 * DIV), 32'h0F0F_0F0F);
        send_request(FUNC_SEARCH, KEY_W'(DIV), '0);
        send_request(FUNC_SEARCH, '0, '0);

        // Limit of zero acts as one.
        set_probe_limit(12'd0);
        send_request(FUNC_INSERT, KEY_W'(3 * DIV), 32'hF0F0_F0F0);
        send_request(FUNC_SEARCH, KEY_W'(3 * DIV), '0);

        // Limit above table size is clamped.
        set_probe_limit(12'hFFF);
        send_request(FUNC_INSERT, KEY_W'(3 * DIV), 32'hDEAD_BEEF);
        send_request(FUNC_SEARCH, KEY_W'(3 * DIV), '0);

        // Limit of two runs out on the home zero chain.
        set_probe_limit(12'd2);
        send_request(FUNC_INSERT, KEY_W'(4 * DIV), 32'h8000_0001);
        send_request(FUNC_SEARCH, KEY_W'(4 * DIV), '0);

        known = '{'0, 31'h7FFF_FFFF, KEY_W'(DIV), KEY_W'(3 * DIV)};

        plan[0] = LIMIT_RESET;
        plan[1] = 12'd3;
        plan[2] = 12'hFFF;
        plan[3] = 12'd1;
        plan[4] = LIMIT_W'($urandom_range(4095, 1));
        plan[5] = 12'd12;
        plan[6] = 12'd0;
        plan[7] = LIMIT_W'($urandom_range(64, 2));

        // Mostly traffic on a few crowded home chains, some scattered keys as noise.
        for (int p = 0; p < PHASES; p++) begin
            set_probe_limit(plan[p]);
            steady <= (p == 2);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                pick = $urandom_range(99);
                if (pick < 55) begin
                    op   = FUNC_INSERT;
                    pick = $urandom_range(99);
                    if (pick < 10) key = known[$urandom_range(known.size() - 1)];
                    else if (pick < 80) key = key_at_home(hot_home[$urandom_range(HOT_HOMES - 1)]);
                    else key = KEY_W'($urandom);
                    known.push_back(key);
                end else begin
                    op   = FUNC_SEARCH;
                    pick = $urandom_range(99);
                    if (pick < 65) key = known[$urandom_range(known.size() - 1)];
                    else if (pick < 90) key = key_at_home(hot_home[$urandom_range(HOT_HOMES - 1)]);
                    else key = KEY_W'($urandom);
                end
                send_request(op, key, $urandom);
            end
        end

        // Drain, then let the engine run out before the verdict.
        s_tvalid <= 1'b0;
        steady   <= 1'b0;
        while (book.outstanding() != 0) @(posedge aclk);
        repeat (32) @(posedge aclk);
        if (book.mismatches == 0 && book.outstanding() == 0) begin
            $display("[open_address_hash_table] OK");
        end else begin
            $display("[open_address_hash_table] ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+src
src/oaht_pkg.sv
src/oaht_mod_unit.sv
src/oaht_datapath.sv
src/oaht_ctrl.sv
src/open_address_hash_table.sv
tb/open_address_hash_table_test.sv
